### hdl/rlf_pkg.sv
// Shared types and constants for the RGB linear fade block.
`timescale 1ns / 1ps
`default_nettype none
package rlf_pkg;

  localparam int LVL_W     = 8;
  localparam int STEP_W    = 7;
  localparam int MAX_STEPS = 64;
  localparam int PROD_W    = 14;  // 255 * 64 fits in 14 bits
  localparam int DIV_ITERS = PROD_W;
  localparam int CNT_W     = 4;
  localparam int NUM_CH    = 3;
  localparam int CH_W      = 2;

  localparam logic [LVL_W-1:0] LVL_MAX = 8'd255;

  typedef struct packed {
    logic [LVL_W-1:0]  target_red;
    logic [LVL_W-1:0]  target_green;
    logic [LVL_W-1:0]  target_blue;
    logic [STEP_W-1:0] step_count;
  } rlf_in_t;

  typedef struct packed {
    logic [LVL_W-1:0] red_level;
    logic [LVL_W-1:0] green_level;
    logic [LVL_W-1:0] blue_level;
    logic [LVL_W-1:0] red_compare;
    logic [LVL_W-1:0] green_compare;
    logic [LVL_W-1:0] blue_compare;
    logic             last_step;
  } rlf_out_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic active;
    logic done;
  } rlf_div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_GO,
    ST_WAIT,
    ST_EMIT
  } rlf_state_t;

endpackage
`default_nettype wire

### hdl/rlf_div.sv
// Restoring serial divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rlf_div
  import rlf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [STEP_W-1:0] divisor,
  output rlf_div_stat_t          stat,
  output logic [LVL_W-1:0]       quotient
);

  logic [PROD_W-1:0] work;
  logic [STEP_W-1:0] rem;
  logic [STEP_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              active;
  logic              done;

  logic [STEP_W:0]   trial;
  logic              fits;
  logic [STEP_W-1:0] diff;

  // when the divisor fits, trial - dvs is below dvs, so the low bits carry it
  always_comb begin
    trial = {rem, work[PROD_W-1]};
    fits  = (trial >= {1'b0, dvs});
    diff  = trial[STEP_W-1:0] - dvs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_ITERS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (active) begin
      // remainder stays below the divisor, so it fits in STEP_W bits
      rem  <= fits ? diff : trial[STEP_W-1:0];
      work <= {work[PROD_W-2:0], fits};
    end
  end

  assign stat.active = active;
  assign stat.done   = done;
  assign quotient    = work[LVL_W-1:0];

  a_go_idle: assert property (@(posedge clk) disable iff (rst) go |-> !active)
    else $error("divider launched while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !active)
    else $error("divider done while still active");
  a_done_after: assert property (@(posedge clk) disable iff (rst) done |-> $past(active))
    else $error("divider done without a run");

endmodule
`default_nettype wire

### hdl/rgb_linear_fade_core.sv
// Top level of the RGB linear fade: step sequencer around a shared serial divider.
// Each step runs, per channel, a multiply state, a launch state and a wait on the
// 14-iteration serial divider, then one emit state that registers the result.
// An item of N steps keeps busy high until its last result is emitted. Results
// cannot be stalled. Synchronous reset sets the current color to black and returns
// the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none
module rgb_linear_fade_core
  import rlf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire rlf_in_t cmd,
  output logic         res_valid,
  output rlf_out_t     res
);

  rlf_state_t state, state_next;

  logic [LVL_W-1:0]  cur   [NUM_CH];
  logic [LVL_W-1:0]  from  [NUM_CH];
  logic [LVL_W-1:0]  tgt   [NUM_CH];
  logic [LVL_W-1:0]  span  [NUM_CH];
  logic              up    [NUM_CH];
  logic [LVL_W-1:0]  lvl   [NUM_CH];
  logic [STEP_W-1:0] steps;
  logic [STEP_W-1:0] step;
  logic [CH_W-1:0]   ch;
  logic [PROD_W-1:0] prod;

  logic              div_go;
  rlf_div_stat_t     div_stat;
  logic [LVL_W-1:0]  quo;

  logic [LVL_W-1:0]  cmd_tgt [NUM_CH];
  logic [STEP_W-1:0] steps_sat;
  logic [PROD_W-1:0] prod_full;
  logic              accept;
  logic              last;

  assign cmd_tgt[0] = cmd.target_red;
  assign cmd_tgt[1] = cmd.target_green;
  assign cmd_tgt[2] = cmd.target_blue;

  always_comb begin
    if (cmd.step_count == '0) begin
      steps_sat = STEP_W'(1);
    end else if (cmd.step_count > STEP_W'(MAX_STEPS)) begin
      steps_sat = STEP_W'(MAX_STEPS);
    end else begin
      steps_sat = cmd.step_count;
    end
  end

  assign accept    = start && !busy;
  assign last      = (step == steps);
  assign prod_full = {{(PROD_W - LVL_W){1'b0}}, span[ch]}
                   * {{(PROD_W - STEP_W){1'b0}}, step};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_MUL;
      ST_MUL:  state_next = ST_GO;
      ST_GO:   state_next = ST_WAIT;
      ST_WAIT: begin
        if (div_stat.done) begin
          state_next = (ch == CH_W'(NUM_CH - 1)) ? ST_EMIT : ST_MUL;
        end
      end
      ST_EMIT: state_next = last ? ST_IDLE : ST_MUL;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = 1'b1;
    div_go = 1'b0;
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_GO:   div_go = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        cur[c] <= '0;
      end
    end else begin
      state     <= state_next;
      res_valid <= (state == ST_EMIT);
      if (state == ST_EMIT) begin
        for (int c = 0; c < NUM_CH; c++) begin
          cur[c] <= lvl[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      steps <= steps_sat;
      step  <= STEP_W'(1);
      ch    <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        from[c] <= cur[c];
        tgt[c]  <= cmd_tgt[c];
        up[c]   <= (cmd_tgt[c] > cur[c]);
        span[c] <= (cmd_tgt[c] > cur[c]) ? (cmd_tgt[c] - cur[c]) : (cur[c] - cmd_tgt[c]);
      end
    end
    if (state == ST_MUL) begin
      prod <= prod_full;
    end
    if (state == ST_WAIT && div_stat.done) begin
      lvl[ch] <= up[ch] ? (from[ch] + quo) : (from[ch] - quo);
      ch      <= (ch == CH_W'(NUM_CH - 1)) ? '0 : ch + 1'b1;
    end
    if (state == ST_EMIT) begin
      res.red_level     <= lvl[0];
      res.green_level   <= lvl[1];
      res.blue_level    <= lvl[2];
      res.red_compare   <= LVL_MAX - lvl[0];
      res.green_compare <= LVL_MAX - lvl[1];
      res.blue_compare  <= LVL_MAX - lvl[2];
      res.last_step     <= last;
      step              <= step + 1'b1;
    end
  end

  rlf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (prod),
    .divisor  (steps),
    .stat     (div_stat),
    .quotient (quo)
  );

  a_lands: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && last) |=> (cur[0] == tgt[0] && cur[1] == tgt[1] && cur[2] == tgt[2]))
    else $error("fade did not land on target");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(state == ST_EMIT))
    else $error("result strobe without emit");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> (step != '0 && step <= steps))
    else $error("step index out of range");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_WAIT)
    else $error("divider finished outside wait");

endmodule
`default_nettype wire

### sim/tb_rgb_linear_fade_core.sv
// Testbench for rgb_linear_fade_core: directed and random fades checked step by step.
`timescale 1ns / 1ps
module tb_rgb_linear_fade_core;
  import rlf_pkg::*;

  localparam int N_RANDOM     = 444;
  localparam int WATCHDOG_MAX = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 10;

  // one directed item; final_res is checked only where typed is set
  typedef struct packed {
    rlf_in_t  cmd;
    logic     typed;
    rlf_out_t final_res;
  } fade_row_t;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  rlf_in_t  cmd;
  logic     res_valid;
  rlf_out_t res;

  logic     cmd_typed;
  rlf_out_t cmd_final;

  logic [LVL_W-1:0] color_now [NUM_CH];
  rlf_out_t         step_q [$];
  fade_row_t        fade_rows [$];
  int               err_cnt;
  int               quiet_cycles;
  int               idle_pct;

  rgb_linear_fade_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic string fmt_step(input rlf_out_t s);
    return $sformatf("lvl %0d/%0d/%0d cmp %0d/%0d/%0d last %0b",
                     s.red_level, s.green_level, s.blue_level,
                     s.red_compare, s.green_compare, s.blue_compare, s.last_step);
  endfunction

  // Expands one fade into its per-step levels and advances the held color.
  task automatic predict_fade(input rlf_in_t c);
    logic [LVL_W-1:0] from_lvl [NUM_CH];
    logic [LVL_W-1:0] to_lvl [NUM_CH];
    logic [LVL_W-1:0] lvl [NUM_CH];
    int unsigned      n;
    int unsigned      i;
    int unsigned      span;
    int unsigned      part;
    int               ch;
    rlf_out_t         r;
    n = c.step_count;
    if (n < 1) n = 1;
    if (n > MAX_STEPS) n = MAX_STEPS;
    to_lvl[0] = c.target_red;
    to_lvl[1] = c.target_green;
    to_lvl[2] = c.target_blue;
    for (ch = 0; ch < NUM_CH; ch++) from_lvl[ch] = color_now[ch];
    for (i = 1; i <= n; i++) begin
      for (ch = 0; ch < NUM_CH; ch++) begin
        if (to_lvl[ch] > from_lvl[ch]) begin
          span = to_lvl[ch] - from_lvl[ch];
          part = (span * i) / n;
          lvl[ch] = LVL_W'(from_lvl[ch] + part);
        end else begin
          span = from_lvl[ch] - to_lvl[ch];
          part = (span * i) / n;
          lvl[ch] = LVL_W'(from_lvl[ch] - part);
        end
      end
      r.red_level     = lvl[0];
      r.green_level   = lvl[1];
      r.blue_level    = lvl[2];
      r.red_compare   = LVL_MAX - lvl[0];
      r.green_compare = LVL_MAX - lvl[1];
      r.blue_compare  = LVL_MAX - lvl[2];
      r.last_step     = (i == n);
      step_q.push_back(r);
    end
    for (ch = 0; ch < NUM_CH; ch++) color_now[ch] = lvl[ch];
  endtask

  // random targets lean toward the rails and the current level
  function automatic logic [LVL_W-1:0] pick_level(input logic [LVL_W-1:0] now_lvl);
    case ($urandom_range(9))
      0: return '0;
      1: return LVL_MAX;
      2: return now_lvl;
      3: return now_lvl + 8'd1;
      4: return now_lvl - 8'd1;
      default: return LVL_W'($urandom);
    endcase
  endfunction

  // short fades mostly, so the run stays within budget
  function automatic logic [STEP_W-1:0] pick_steps();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 85) return STEP_W'($urandom_range(8));
    if (sel < 90) return STEP_W'(MAX_STEPS);
    return STEP_W'($urandom_range(127, 9));
  endfunction

  // Presents one item from a falling edge and returns at the edge that takes it.
  task automatic issue(input fade_row_t row, input logic rand_item);
    rlf_in_t c;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    c = row.cmd;
    if (rand_item) begin
      c.target_red   = pick_level(color_now[0]);
      c.target_green = pick_level(color_now[1]);
      c.target_blue  = pick_level(color_now[2]);
      c.step_count   = pick_steps();
    end
    start     <= 1'b1;
    cmd       <= c;
    cmd_typed <= row.typed;
    cmd_final <= row.final_res;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  always @(posedge clk) begin : step_check
    rlf_out_t want;
    logic     moved;
    moved = 1'b0;
    if (rst) begin
      color_now[0] = '0;
      color_now[1] = '0;
      color_now[2] = '0;
    end else begin
      if (start && busy === 1'b0) begin
        moved = 1'b1;
        predict_fade(cmd);
        if (cmd_typed) step_q[step_q.size()-1] = cmd_final;
      end
      if (res_valid === 1'b1) begin
        if (step_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) $display("unexpected item out: %s", fmt_step(res));
        end else begin
          moved = 1'b1;
          want = step_q.pop_front();
          if (res.red_level !== want.red_level || res.green_level !== want.green_level ||
              res.blue_level !== want.blue_level || res.red_compare !== want.red_compare ||
              res.green_compare !== want.green_compare ||
              res.blue_compare !== want.blue_compare || res.last_step !== want.last_step)
          begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("step mismatch: expected %s, got %s", fmt_step(want), fmt_step(res));
          end
        end
      end
    end
    // stray results do not count as progress, so a runaway block still trips this
    if (moved) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    fade_row_t blank;
    int        ph;
    int        k;
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = '0;
    cmd_typed    = 1'b0;
    cmd_final    = '0;
    err_cnt      = 0;
    quiet_cycles = 0;
    idle_pct     = 0;
    blank        = '0;

    // target, steps | typed last step where it is plain to see
    fade_rows.push_back('{'{8'd255, 8'd0, 8'd128, 7'd1}, 1'b1,
                          '{8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd127, 1'b1}});
    // zero steps acts as one
    fade_rows.push_back('{'{8'd0, 8'd255, 8'd0, 7'd0}, 1'b1,
                          '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b1}});
    fade_rows.push_back('{'{8'd255, 8'd255, 8'd255, 7'd64}, 1'b1,
                          '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1}});
    // step count saturates at the maximum
    fade_rows.push_back('{'{8'd0, 8'd0, 8'd0, 7'd127}, 1'b1,
                          '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1}});
    // target equals current level
    fade_rows.push_back('{'{8'd0, 8'd0, 8'd0, 7'd5}, 1'b0, '0});
    fade_rows.push_back('{'{8'd200, 8'd100, 8'd50, 7'd3}, 1'b0, '0});
    fade_rows.push_back('{'{8'd10, 8'd240, 8'd128, 7'd7}, 1'b0, '0});
    fade_rows.push_back('{'{8'd10, 8'd240, 8'd128, 7'd2}, 1'b0, '0});
    fade_rows.push_back('{'{8'd255, 8'd0, 8'd255, 7'd65}, 1'b0, '0});
    fade_rows.push_back('{'{8'd0, 8'd255, 8'd0, 7'd64}, 1'b0, '0});
    fade_rows.push_back('{'{8'd128, 8'd128, 8'd128, 7'd1}, 1'b0, '0});
    fade_rows.push_back('{'{8'd1, 8'd254, 8'd127, 7'd63}, 1'b0, '0});
    fade_rows.push_back('{'{8'd0, 8'd1, 8'd0, 7'd96}, 1'b0, '0});
    fade_rows.push_back('{'{8'd170, 8'd85, 8'd170, 7'd42}, 1'b0, '0});
    fade_rows.push_back('{'{8'd85, 8'd170, 8'd85, 7'd21}, 1'b0, '0});
    fade_rows.push_back('{'{8'd86, 8'd169, 8'd84, 7'd6}, 1'b0, '0});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < fade_rows.size(); k++) issue(fade_rows[k], 1'b0);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        1: idle_pct = 57;
        2: idle_pct = 26;
        default: idle_pct = 0;
      endcase
      if (ph == 2) begin
        // hold off until the block has drained
        @(negedge clk);
        start <= 1'b0;
        while (step_q.size() != 0) @(negedge clk);
      end
      for (k = 0; k < N_RANDOM / 4; k++) issue(blank, 1'b1);
    end

    @(negedge clk);
    start <= 1'b0;
    while (step_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0 && step_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
